[sv/rsc_pkg.sv]
`timescale 1ns / 1ps

package rsc_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int WORD_W      = 32;
   localparam int DIV_STEPS   = WORD_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_POP  = 3'd1,
      OP_DUP  = 3'd2,
      OP_ADD  = 3'd3,
      OP_SUB  = 3'd4,
      OP_MUL  = 3'd5,
      OP_DIV  = 3'd6,
      OP_EXIT = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_FEW     = 3'd2,
      ST_DIVZERO = 3'd3,
      ST_HALTED  = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_B,
      S_READ_A,
      S_EXEC,
      S_DIV,
      S_WB,
      S_DONE
   } state_type;

   typedef struct packed {
      opcode_type         opcode;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] result_value;
      logic               result_valid;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [PTR_W-1:0]  waddr;
      logic [WORD_W-1:0] wdata;
      logic              re;
      logic [PTR_W-1:0]  raddr;
   } ram_req_type;

endpackage

[sv/rsc_stack_ram.sv]
`timescale 1ns / 1ps

module rsc_stack_ram (
   input  logic                       clock,
   input  rsc_pkg::ram_req_type       ram_req,
   output logic [rsc_pkg::WORD_W-1:0] rd_data
);

   logic [rsc_pkg::WORD_W-1:0] mem [rsc_pkg::STACK_DEPTH];
   logic [rsc_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rd_data_ff <= mem[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/rsc_divider.sv]
`timescale 1ns / 1ps

module rsc_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rsc_pkg::WORD_W-1:0] dividend,
   input  logic [rsc_pkg::WORD_W-1:0] divisor,
   output logic                       done,
   output logic [rsc_pkg::WORD_W-1:0] quotient
);

   localparam int W = rsc_pkg::WORD_W;

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [rsc_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]                   rem_ff, rem_in;
   logic [W-1:0]                   q_ff, q_in;
   logic [W-1:0]                   mb_ff, mb_in;
   logic                           neg_ff, neg_in;
   logic [W:0]                     trial;
   logic [W:0]                     diff;
   logic                           ge;

   assign trial = {rem_ff, q_ff[W-1]};
   assign diff  = trial - {1'b0, mb_ff};
   assign ge    = !diff[W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = rsc_pkg::DIV_CNT_W'(rsc_pkg::DIV_STEPS - 1);
         rem_in  = '0;
         q_in    = dividend[W-1] ? (W'(0) - dividend) : dividend;
         mb_in   = divisor[W-1] ? (W'(0) - divisor) : divisor;
         neg_in  = dividend[W-1] ^ divisor[W-1];
      end else if (busy_ff) begin
         rem_in = ge ? diff[W-1:0] : trial[W-1:0];
         q_in   = {q_ff[W-2:0], ge};
         cnt_in = cnt_ff - rsc_pkg::DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (W'(0) - q_ff) : q_ff;

endmodule

[sv/rpn_stack_calculator.sv]
`timescale 1ns / 1ps

// RPN stack calculator over 32-bit wrapping integers with a 64-word stack held in a
// single-port-read synchronous RAM. One word is taken at a time and answered with
// exactly one response word. Push, halted and stack-bound error cases answer without a
// stack read, pop and dup read the top word first, and add/sub/mul/div make two sequential
// operand reads from the stack RAM, a nonzero divide then running the 32-step shift-subtract
// divider. A new word is accepted while the previous response still waits on rsp_ready.
// After exit or a divide by zero every word answers halted until reset.

module rpn_stack_calculator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsc_pkg::rsp_type rsp_data
);

   localparam int CW = rsc_pkg::CNT_W;
   localparam int PW = rsc_pkg::PTR_W;
   localparam int W  = rsc_pkg::WORD_W;

   rsc_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 halted_ff, halted_in;
   rsc_pkg::opcode_type  op_ff, op_in;
   logic [W-1:0]         a_ff, a_in;
   logic [W-1:0]         b_ff, b_in;
   logic [W-1:0]         res_ff, res_in;
   rsc_pkg::rsp_type     pend_ff, pend_in;
   rsc_pkg::rsp_type     rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   rsc_pkg::ram_req_type ram_req;
   logic [W-1:0]         rd_data;
   logic                 div_start;
   logic                 div_done;
   logic [W-1:0]         div_q;

   logic [CW-1:0]        cnt_m1;
   logic [CW-1:0]        cnt_m2;
   logic                 is_full;
   logic                 accept;

   assign cnt_m1  = count_ff - CW'(1);
   assign cnt_m2  = count_ff - CW'(2);
   assign is_full = count_ff >= CW'(rsc_pkg::STACK_DEPTH);
   assign accept  = req_valid && req_ready;

   rsc_stack_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   rsc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_ff),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      halted_in    = halted_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      res_in       = res_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_req      = '0;
      div_start    = 1'b0;
      req_ready    = (state_ff == rsc_pkg::S_IDLE);

      unique case (state_ff)
         rsc_pkg::S_IDLE: begin
            if (accept) begin
               op_in    = req_data.opcode;
               pend_in  = '{status: rsc_pkg::ST_OK, result_value: '0, result_valid: 1'b0};
               state_in = rsc_pkg::S_DONE;
               if (halted_ff) begin
                  pend_in.status = rsc_pkg::ST_HALTED;
               end else begin
                  unique case (req_data.opcode)
                     rsc_pkg::OP_PUSH: begin
                        if (is_full) begin
                           pend_in.status = rsc_pkg::ST_FULL;
                        end else begin
                           ram_req.we    = 1'b1;
                           ram_req.waddr = count_ff[PW-1:0];
                           ram_req.wdata = req_data.push_value;
                           count_in      = count_ff + CW'(1);
                        end
                     end
                     rsc_pkg::OP_POP: begin
                        if (count_ff == '0) begin
                           pend_in.status = rsc_pkg::ST_EMPTY;
                        end else begin
                           ram_req.re    = 1'b1;
                           ram_req.raddr = cnt_m1[PW-1:0];
                           state_in      = rsc_pkg::S_READ_B;
                        end
                     end
                     rsc_pkg::OP_DUP: begin
                        if (count_ff == '0) begin
                           pend_in.status = rsc_pkg::ST_EMPTY;
                        end else if (is_full) begin
                           pend_in.status = rsc_pkg::ST_FULL;
                        end else begin
                           ram_req.re    = 1'b1;
                           ram_req.raddr = cnt_m1[PW-1:0];
                           state_in      = rsc_pkg::S_READ_B;
                        end
                     end
                     rsc_pkg::OP_EXIT: begin
                        halted_in = 1'b1;
                     end
                     rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_MUL,
                     rsc_pkg::OP_DIV: begin
                        if (count_ff < CW'(2)) begin
                           pend_in.status = rsc_pkg::ST_FEW;
                        end else begin
                           ram_req.re    = 1'b1;
                           ram_req.raddr = cnt_m1[PW-1:0];
                           state_in      = rsc_pkg::S_READ_B;
                        end
                     end
                  endcase
               end
            end
         end
         rsc_pkg::S_READ_B: begin
            b_in     = rd_data;
            state_in = rsc_pkg::S_DONE;
            priority case (op_ff)
               rsc_pkg::OP_POP: begin
                  count_in = cnt_m1;
                  pend_in  = '{status: rsc_pkg::ST_OK, result_value: rd_data,
                               result_valid: 1'b1};
               end
               rsc_pkg::OP_DUP: begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = count_ff[PW-1:0];
                  ram_req.wdata = rd_data;
                  count_in      = count_ff + CW'(1);
               end
               default: begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = cnt_m2[PW-1:0];
                  state_in      = rsc_pkg::S_READ_A;
               end
            endcase
         end
         rsc_pkg::S_READ_A: begin
            a_in     = rd_data;
            state_in = rsc_pkg::S_EXEC;
         end
         rsc_pkg::S_EXEC: begin
            state_in = rsc_pkg::S_WB;
            priority case (op_ff)
               rsc_pkg::OP_ADD: res_in = a_ff + b_ff;
               rsc_pkg::OP_SUB: res_in = a_ff - b_ff;
               rsc_pkg::OP_MUL: res_in = a_ff * b_ff;
               default: begin
                  if (b_ff == '0) begin
                     count_in       = cnt_m2;
                     halted_in      = 1'b1;
                     pend_in.status = rsc_pkg::ST_DIVZERO;
                     state_in       = rsc_pkg::S_DONE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = rsc_pkg::S_DIV;
                  end
               end
            endcase
         end
         rsc_pkg::S_DIV: begin
            if (div_done) begin
               res_in   = div_q;
               state_in = rsc_pkg::S_WB;
            end
         end
         rsc_pkg::S_WB: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = cnt_m2[PW-1:0];
            ram_req.wdata = res_ff;
            count_in      = cnt_m1;
            pend_in       = '{status: rsc_pkg::ST_OK, result_value: res_ff,
                              result_valid: 1'b1};
            state_in      = rsc_pkg::S_DONE;
         end
         rsc_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = rsc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rsc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsc_pkg::S_IDLE;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      res_ff  <= res_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/rsc_checker.sv]
`timescale 1ns / 1ps

module rsc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsc_pkg::rsp_type rsp_data
);

   // response word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word dropped or changed while stalled");

   // no value without a valid result
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.result_valid |-> rsp_data.result_value == '0)
      else $error("result value nonzero without result valid");

   // a value only comes with ok status
   a_valid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_valid |-> rsp_data.status == rsc_pkg::ST_OK)
      else $error("result valid with error status");

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind rpn_stack_calculator rsc_checker u_rsc_checker (.*);
